// ===== src/dphu_pkg.sv =====
// shared types, constants and the microcode rom of the decimating power history unit
// no dependencies; used by dphu_seq, dphu_dp and the top level
package dphu_pkg;

  localparam logic [15:0] COEF_RESET = 16'd4186;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_MUL1   = 4'd1;
  localparam step_t ST_MUL2   = 4'd2;
  localparam step_t ST_CHECK  = 4'd3;
  localparam step_t ST_RD_A   = 4'd4;
  localparam step_t ST_RD_B   = 4'd5;
  localparam step_t ST_WR_AVG = 4'd6;
  localparam step_t ST_RD_END = 4'd7;
  localparam step_t ST_WR_CPY = 4'd8;
  localparam step_t ST_COMMIT = 4'd9;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_IN,
    C_NOT_FULL,
    C_MORE_PAIRS,
    C_EVEN_DEPTH,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic latch_in;
    logic mul1;
    logic mul2;
    logic clr_k;
    logic rd_a;
    logic rd_b;
    logic wr_avg;
    logic rd_last;
    logic fin_halve;
    logic wr_copy;
    logic commit;
  } act_t;

  typedef struct packed {
    cond_t cond;
    step_t jump;
    step_t next;
    act_t  act;
  } uword_t;

  typedef struct packed {
    logic out_busy;
    logic not_full;
    logic more_pairs;
    logic even_depth;
  } dp_stat_t;

  // on a true condition the step goes to jump, otherwise to next
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w      = '0;
    w.cond = C_ALWAYS;
    case (s)
      ST_IDLE: begin
        w.cond = C_NO_IN;   w.jump = ST_IDLE;   w.next = ST_MUL1;  w.act.latch_in = 1'b1;
      end
      ST_MUL1: begin
        w.jump = ST_MUL2;   w.next = ST_MUL2;   w.act.mul1 = 1'b1;
      end
      ST_MUL2: begin
        w.jump = ST_CHECK;  w.next = ST_CHECK;  w.act.mul2 = 1'b1;
      end
      ST_CHECK: begin
        w.cond = C_NOT_FULL; w.jump = ST_COMMIT; w.next = ST_RD_A; w.act.clr_k = 1'b1;
      end
      ST_RD_A: begin
        w.jump = ST_RD_B;   w.next = ST_RD_B;   w.act.rd_a = 1'b1;
      end
      ST_RD_B: begin
        w.jump = ST_WR_AVG; w.next = ST_WR_AVG; w.act.rd_b = 1'b1;
      end
      ST_WR_AVG: begin
        w.cond = C_MORE_PAIRS; w.jump = ST_RD_A; w.next = ST_RD_END; w.act.wr_avg = 1'b1;
      end
      ST_RD_END: begin
        w.cond = C_EVEN_DEPTH; w.jump = ST_COMMIT; w.next = ST_WR_CPY;
        w.act.rd_last   = 1'b1;
        w.act.fin_halve = 1'b1;
      end
      ST_WR_CPY: begin
        w.jump = ST_COMMIT; w.next = ST_COMMIT; w.act.wr_copy = 1'b1;
      end
      ST_COMMIT: begin
        w.cond = C_OUT_BUSY; w.jump = ST_COMMIT; w.next = ST_IDLE; w.act.commit = 1'b1;
      end
      default: begin
        w.jump = ST_IDLE;   w.next = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/decimating_power_history_unit.sv =====
// Decimating power history unit.
// Each input request (inlet temp, outlet temp, flow) gives power = coefficient * flow * rise,
// with a negative rise taken as zero and the product saturated at 32 bits. The power goes
// into a HISTORY_DEPTH-entry history memory; a full memory is first halved by averaging
// adjacent pairs, and the halving count (saturating) goes up by one.
// One result per request: halving count, power, running peak and entries held.
// Channels: in_* and out_* are valid/ready; cfg_wr_en writes the coefficient at once. The user
// must write it only while the unit is idle; the block itself does not enforce this. Reset sets
// the coefficient to 4186 and clears the counters and the peak; the memory needs no clearing.
// Sequence: an accepted request passes the MUL1, MUL2 and CHECK steps to COMMIT, where the result
// register loads, and the unit then returns to IDLE, where the next request can be taken. When
// the memory is full, CHECK is followed by the pair loop of read, read, write on the single
// memory port, then a read of the last entry and, for an odd depth, a copy of it, before COMMIT.
// One request is worked at a time; the next is accepted while a result still waits in the
// output register. If the receiver stalls, the next result holds in its commit step and
// no further request is taken.
// Depends on dphu_pkg, dphu_seq and dphu_dp.
module decimating_power_history_unit
  import dphu_pkg::*;
#(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_inlet_temp,
  input  logic [7:0]  in_outlet_temp,
  input  logic [15:0] in_flow,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_time_scale,
  output logic [31:0] out_sample_power,
  output logic [31:0] out_peak_power,
  output logic [7:0]  out_entries_held,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  act_t     act;
  dp_stat_t stat;

  dphu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .act      (act),
    .in_ready (in_ready)
  );

  dphu_dp #(
    .DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .act              (act),
    .in_inlet_temp    (in_inlet_temp),
    .in_outlet_temp   (in_outlet_temp),
    .in_flow          (in_flow),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_time_scale   (out_time_scale),
    .out_sample_power (out_sample_power),
    .out_peak_power   (out_peak_power),
    .out_entries_held (out_entries_held),
    .stat             (stat)
  );

endmodule

// ===== src/dphu_seq.sv =====
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on dphu_pkg
module dphu_seq
  import dphu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output act_t     act,
  output logic     in_ready
);

  step_t  step_r, step_nxt;
  uword_t w;
  logic   cond_met;

  assign w = ucode_rom(step_r);

  always_comb begin
    case (w.cond)
      C_ALWAYS:     cond_met = 1'b1;
      C_NO_IN:      cond_met = !in_valid;
      C_NOT_FULL:   cond_met = stat.not_full;
      C_MORE_PAIRS: cond_met = stat.more_pairs;
      C_EVEN_DEPTH: cond_met = stat.even_depth;
      C_OUT_BUSY:   cond_met = stat.out_busy;
      default:      cond_met = 1'b1;
    endcase
    step_nxt = cond_met ? w.jump : w.next;
  end

  // wait steps only act once their handshake goes through
  always_comb begin
    act          = w.act;
    act.latch_in = w.act.latch_in & in_valid;
    act.commit   = w.act.commit & !stat.out_busy;
  end

  assign in_ready = w.act.latch_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== src/dphu_dp.sv =====
// datapath: coefficient register, two-step multiply, history memory with pair averaging,
// counters and the output register; depends on dphu_pkg
module dphu_dp
  import dphu_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  act_t        act,
  input  logic [7:0]  in_inlet_temp,
  input  logic [7:0]  in_outlet_temp,
  input  logic [15:0] in_flow,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] out_time_scale,
  output logic [31:0] out_sample_power,
  output logic [31:0] out_peak_power,
  output logic [7:0]  out_entries_held,
  output dp_stat_t    stat
);

  localparam int AW        = $clog2(DEPTH);
  localparam int FW        = $clog2(DEPTH + 1);
  localparam int PAIRS     = DEPTH / 2;
  localparam int HALF_FILL = (DEPTH + 1) / 2;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   mem_q;
  logic [31:0]   a_r;
  logic [AW-1:0] k_r;
  logic [FW-1:0] fill_r, fill_inc;
  logic [15:0]   halv_r;
  logic [31:0]   peak_r, peak_nxt;
  logic [15:0]   coef_r;
  logic [15:0]   flow_r;
  logic [7:0]    rise_r;
  logic [31:0]   p1_r;
  logic [39:0]   prod;
  logic [31:0]   power_r;
  logic          out_valid_r;
  logic [32:0]   pair_sum;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;

  assign pair_sum = {1'b0, a_r} + {1'b0, mem_q};
  assign prod     = 40'(p1_r) * 40'(rise_r);
  assign fill_inc = fill_r + FW'(1);
  assign peak_nxt = (power_r > peak_r) ? power_r : peak_r;

  // memory port selection
  always_comb begin
    wr_en   = act.wr_avg | act.wr_copy | act.commit;
    wr_addr = act.commit ? fill_r[AW-1:0] : k_r;
    wr_data = act.wr_avg ? pair_sum[32:1] : (act.commit ? power_r : mem_q);
    rd_en   = act.rd_a | act.rd_b | act.rd_last;
    if (act.rd_last) begin
      rd_addr = AW'(DEPTH - 1);
    end else begin
      rd_addr = {k_r[AW-2:0], act.rd_b};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign stat.out_busy   = out_valid_r & !out_ready;
  assign stat.not_full   = fill_r < FW'(DEPTH);
  assign stat.more_pairs = ((AW + 1)'(k_r) + (AW + 1)'(1)) < (AW + 1)'(PAIRS);
  assign stat.even_depth = (DEPTH % 2) == 0;

  // payload registers
  always_ff @(posedge clk) begin
    if (act.latch_in) begin
      flow_r <= in_flow;
      rise_r <= (in_outlet_temp > in_inlet_temp) ? (in_outlet_temp - in_inlet_temp) : 8'd0;
    end
    if (act.mul1) begin
      p1_r <= 32'(coef_r) * 32'(flow_r);
    end
    if (act.mul2) begin
      power_r <= (|prod[39:32]) ? 32'hFFFF_FFFF : prod[31:0];
    end
    if (act.rd_b) begin
      a_r <= mem_q;
    end
    if (act.clr_k) begin
      k_r <= '0;
    end else if (act.wr_avg) begin
      k_r <= k_r + AW'(1);
    end
    if (act.commit) begin
      out_time_scale   <= halv_r;
      out_sample_power <= power_r;
      out_peak_power   <= peak_nxt;
      out_entries_held <= 8'(fill_inc);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r      <= COEF_RESET;
      fill_r      <= '0;
      halv_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        coef_r <= cfg_wr_data;
      end
      if (act.fin_halve) begin
        fill_r <= FW'(HALF_FILL);
        if (halv_r != 16'hFFFF) begin
          halv_r <= halv_r + 16'd1;
        end
      end else if (act.commit) begin
        fill_r <= fill_inc;
      end
      if (act.commit) begin
        peak_r      <= peak_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/dphu_checker.sv =====
// port-level checks for decimating_power_history_unit, attached by bind
// depends on the top level's ports only
module dphu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sample_power,
  input logic [31:0] out_peak_power
);

  // one request at a time
  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample_power) && $stable(out_peak_power))
    else $error("result changed while stalled");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_power >= out_sample_power)
    else $error("peak below sample power");

  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) |-> out_peak_power >= $past(out_peak_power))
    else $error("peak decreased");

endmodule

bind decimating_power_history_unit dphu_checker u_dphu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sample_power (out_sample_power),
  .out_peak_power   (out_peak_power)
);
